FILE: sv/counting_semaphore_wait_queue_top_macros.svh
// ----------------------------------------------------------------------------
// Counting semaphore wait queue: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_TOP_MACROS_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_TOP_MACROS_SVH

// ante implies cons in the same cycle
`define CSQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csq: implication violated");

// ante implies cons in the next cycle
`define CSQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csq: next-cycle implication violated");

// expr never holds
`define CSQ_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("csq: forbidden condition seen");

`endif

FILE: sv/csq_pkg.sv
// ----------------------------------------------------------------------------
// Counting semaphore wait queue package
// Transaction types, operation and status codes, control structs.
// ----------------------------------------------------------------------------
package csq_pkg;

   localparam int THREAD_ID_W = 8;
   localparam int COUNT_W     = 17;
   localparam int CFG_W       = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 17'd65535;

   localparam logic [1:0] MODE_WAIT    = 2'd0;
   localparam logic [1:0] MODE_SIGNAL  = 2'd1;
   localparam logic [1:0] MODE_TRYWAIT = 2'd2;
   localparam logic [1:0] MODE_CLOSE   = 2'd3;

   localparam logic [2:0] STATUS_SUCCESS    = 3'd0;
   localparam logic [2:0] STATUS_BLOCKED    = 3'd1;
   localparam logic [2:0] STATUS_LOCKED     = 3'd2;
   localparam logic [2:0] STATUS_CLOSED     = 3'd3;
   localparam logic [2:0] STATUS_QUEUE_FULL = 3'd4;

   localparam logic WAKE_SIGNALED = 1'b0;
   localparam logic WAKE_CLOSED   = 1'b1;

   typedef struct packed {
      logic [1:0]             mode;
      logic [THREAD_ID_W-1:0] thread_id;
   } req_type;

   typedef struct packed {
      logic [2:0]             status;
      logic                   released_valid;
      logic [THREAD_ID_W-1:0] released_id;
      logic                   wake_code;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic pop;
      logic cfg;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic close_more;
      logic pop_more;
   } ctl_sts_type;

endpackage

FILE: sv/csq_ctrl.sv
// ----------------------------------------------------------------------------
// Counting semaphore controller
// Sequences accept, execute and close drain; owns the handshake controls.
// ----------------------------------------------------------------------------
module csq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  csq_pkg::ctl_sts_type sts,
   output csq_pkg::ctl_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_POP  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign csr_ready = !reset && (state_ff == S_IDLE);
   assign req_stall = reset || (state_ff != S_IDLE) || csr_valid;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.cfg    = csr_valid && csr_ready;
      cmd.accept = req_valid && !req_stall;
      case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.out_free) begin
               cmd.exec = 1'b1;
               state_in = sts.close_more ? S_WAIT : S_IDLE;
            end
         end
         S_WAIT: begin
            state_in = S_POP;
         end
         S_POP: begin
            if (sts.out_free) begin
               cmd.pop  = 1'b1;
               state_in = sts.pop_more ? S_WAIT : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/csq_datapath.sv
// ----------------------------------------------------------------------------
// Counting semaphore datapath
// Count, closed flag, waiter ring buffer and result register.
// ----------------------------------------------------------------------------
module csq_datapath #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  csq_pkg::req_type            req_data,
   input  logic [csq_pkg::CFG_W-1:0]   csr_data,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output csq_pkg::rsp_type            rsp_data,
   input  csq_pkg::ctl_cmd_type        cmd,
   output csq_pkg::ctl_sts_type        sts
);

   localparam int PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int OCC_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int COPY_W   = (ID_BITS < csq_pkg::THREAD_ID_W) ? ID_BITS : csq_pkg::THREAD_ID_W;

   logic [ID_BITS-1:0]           mem_ff [QUEUE_DEPTH];
   logic [ID_BITS-1:0]           rd_ff;
   csq_pkg::req_type             op_ff;
   logic [csq_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                         closed_ff, closed_in;
   logic [PTR_W-1:0]             head_ff, head_in;
   logic [PTR_W-1:0]             tail_ff, tail_in;
   logic [OCC_W-1:0]             occ_ff, occ_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   csq_pkg::rsp_type             rsp_data_ff, rsp_next;
   logic                         rsp_load;
   logic                         wr_en;
   logic [ID_BITS-1:0]           wr_id;
   logic [csq_pkg::THREAD_ID_W-1:0] rel_id;
   logic [PTR_W-1:0]             head_nx, tail_nx;
   logic                         cnt_neg, cnt_le0, q_full, q_some;

   assign head_nx = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
   assign tail_nx = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
   assign cnt_neg = count_ff[csq_pkg::COUNT_W-1];
   assign cnt_le0 = cnt_neg || (count_ff == '0);
   assign q_full  = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign q_some  = (occ_ff != '0);

   always_comb begin
      wr_id  = '0;
      rel_id = '0;
      for (int i = 0; i < COPY_W; i++) begin
         wr_id[i]  = op_ff.thread_id[i];
         rel_id[i] = rd_ff[i];
      end
   end

   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;
   assign sts.pop_more   = (occ_ff > OCC_W'(1));
   assign sts.close_more = (op_ff.mode == csq_pkg::MODE_CLOSE) && !closed_ff && sts.pop_more;

   always_comb begin
      count_in  = count_ff;
      closed_in = closed_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      wr_en     = 1'b0;
      rsp_load  = 1'b0;
      rsp_next  = '0;
      rsp_next.last = 1'b1;
      if (cmd.cfg) begin
         count_in  = {1'b0, csr_data};
         closed_in = 1'b0;
         head_in   = '0;
         tail_in   = '0;
         occ_in    = '0;
      end else if (cmd.exec) begin
         rsp_load = 1'b1;
         if (closed_ff) begin
            rsp_next.status = csq_pkg::STATUS_CLOSED;
         end else begin
            case (op_ff.mode)
               csq_pkg::MODE_WAIT: begin
                  if (cnt_le0 && q_full) begin
                     rsp_next.status = csq_pkg::STATUS_QUEUE_FULL;
                  end else if (cnt_le0) begin
                     count_in = count_ff - csq_pkg::COUNT_W'(1);
                     wr_en    = 1'b1;
                     tail_in  = tail_nx;
                     occ_in   = occ_ff + OCC_W'(1);
                     rsp_next.status = csq_pkg::STATUS_BLOCKED;
                  end else begin
                     count_in = count_ff - csq_pkg::COUNT_W'(1);
                  end
               end
               csq_pkg::MODE_SIGNAL: begin
                  if (count_ff != csq_pkg::COUNT_MAX) begin
                     count_in = count_ff + csq_pkg::COUNT_W'(1);
                  end
                  if (cnt_neg && q_some) begin
                     head_in = head_nx;
                     occ_in  = occ_ff - OCC_W'(1);
                     rsp_next.released_valid = 1'b1;
                     rsp_next.released_id    = rel_id;
                     rsp_next.wake_code      = csq_pkg::WAKE_SIGNALED;
                  end
               end
               csq_pkg::MODE_TRYWAIT: begin
                  if (cnt_le0) begin
                     rsp_next.status = csq_pkg::STATUS_LOCKED;
                  end else begin
                     count_in = count_ff - csq_pkg::COUNT_W'(1);
                  end
               end
               csq_pkg::MODE_CLOSE: begin
                  closed_in = 1'b1;
                  if (q_some) begin
                     head_in = head_nx;
                     occ_in  = occ_ff - OCC_W'(1);
                     rsp_next.released_valid = 1'b1;
                     rsp_next.released_id    = rel_id;
                     rsp_next.wake_code      = csq_pkg::WAKE_CLOSED;
                     rsp_next.last           = !sts.pop_more;
                  end
               end
               default: begin
                  rsp_next.status = csq_pkg::STATUS_SUCCESS;
               end
            endcase
         end
      end else if (cmd.pop) begin
         rsp_load = 1'b1;
         head_in  = head_nx;
         occ_in   = occ_ff - OCC_W'(1);
         rsp_next.released_valid = 1'b1;
         rsp_next.released_id    = rel_id;
         rsp_next.wake_code      = csq_pkg::WAKE_CLOSED;
         rsp_next.last           = !sts.pop_more;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         closed_ff    <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         closed_ff    <= closed_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   // waiter ring buffer, registered read at the head
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[tail_ff] <= wr_id;
      end
      rd_ff <= mem_ff[head_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: sv/counting_semaphore_wait_queue_top.sv
// Results are registered; a new transaction is taken only after the last one
// has executed. A close with waiters releases them one at a time, paced by the
// registered read port of the waiter buffer.
// Reset (synchronous): count 0, open, queue empty; waiter storage not cleared.
// ----------------------------------------------------------------------------
// Counting semaphore wait queue top level
// Semaphore with FIFO of blocked thread ids, controller plus datapath.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  csq_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output csq_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [csq_pkg::CFG_W-1:0] csr_data
);

   csq_pkg::ctl_cmd_type cmd;
   csq_pkg::ctl_sts_type sts;

   csq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   csq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

FILE: sv/csq_checker.sv
// ----------------------------------------------------------------------------
// Counting semaphore port checker
// Port-level properties of the semaphore, bound to the top level.
// ----------------------------------------------------------------------------
`include "counting_semaphore_wait_queue_top_macros.svh"

module csq_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input csq_pkg::req_type          req_data,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input csq_pkg::rsp_type          rsp_data,
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic [csq_pkg::CFG_W-1:0] csr_data
);

   logic unused_ok;
   assign unused_ok = ^{req_data, csr_data};

   `CSQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `CSQ_ASSERT_IMPLY(a_idle_fields, clock, reset, rsp_valid && !rsp_data.released_valid, (rsp_data.released_id == '0) && (rsp_data.wake_code == csq_pkg::WAKE_SIGNALED))
   `CSQ_ASSERT_IMPLY(a_fail_single, clock, reset, rsp_valid && (rsp_data.status != csq_pkg::STATUS_SUCCESS), rsp_data.last && !rsp_data.released_valid)
   `CSQ_ASSERT_NEVER(a_cfg_req_clash, clock, reset, req_valid && !req_stall && csr_valid && csr_ready)

endmodule

bind counting_semaphore_wait_queue_top csq_checker u_csq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_data  (csr_data)
);

FILE: sim/counting_semaphore_wait_queue_top_test.sv
// ----------------------------------------------------------------------------
// Counting semaphore wait queue testbench
// Drives wait, signal, trywait and close transactions through the semaphore,
// keeps a shadow of its count, closed flag and waiter FIFO, and compares every
// outcome field by field. Directed corners come first, then randomised phases
// across several initial counts with random idling and a long output hold.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH    = 16;
   localparam int ID_BITS        = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NUM_PHASES     = 10;
   localparam int PHASE_OPS      = 26;

   class semaphore_shadow;
      int       count;
      bit       closed;
      logic [ID_BITS-1:0] blocked_ids[$];
      csq_pkg::rsp_type due_outcomes[$];
      int unsigned mismatches, ops_seen, outcomes_seen;
      int unsigned blocked_seen, full_seen, signal_wakes, close_wakes, closed_seen;

      function void reinit(logic [csq_pkg::CFG_W-1:0] value);
         count  = int'(value);
         closed = 1'b0;
         blocked_ids.delete();
      endfunction

      function void push_outcome(logic [2:0] status, logic rv, logic [7:0] id,
                                 logic wake, logic last);
         csq_pkg::rsp_type r;
         r.status         = status;
         r.released_valid = rv;
         r.released_id    = id;
         r.wake_code      = wake;
         r.last           = last;
         due_outcomes.push_back(r);
      endfunction

      function void apply_operation(csq_pkg::req_type item);
         logic [ID_BITS-1:0] id;
         ops_seen++;
         if (closed) begin
            closed_seen++;
            push_outcome(csq_pkg::STATUS_CLOSED, 1'b0, '0, 1'b0, 1'b1);
            return;
         end
         case (item.mode)
            csq_pkg::MODE_WAIT: begin
               if (count <= 0) begin
                  if (blocked_ids.size() >= QUEUE_DEPTH) begin
                     full_seen++;
                     push_outcome(csq_pkg::STATUS_QUEUE_FULL, 1'b0, '0, 1'b0, 1'b1);
                  end else begin
                     count--;
                     blocked_ids.push_back(item.thread_id);
                     blocked_seen++;
                     push_outcome(csq_pkg::STATUS_BLOCKED, 1'b0, '0, 1'b0, 1'b1);
                  end
               end else begin
                  count--;
                  push_outcome(csq_pkg::STATUS_SUCCESS, 1'b0, '0, 1'b0, 1'b1);
               end
            end
            csq_pkg::MODE_SIGNAL: begin
               if (count < int'(csq_pkg::COUNT_MAX)) count++;
               if (count <= 0 && blocked_ids.size() > 0) begin
                  id = blocked_ids.pop_front();
                  signal_wakes++;
                  push_outcome(csq_pkg::STATUS_SUCCESS, 1'b1, id,
                               csq_pkg::WAKE_SIGNALED, 1'b1);
               end else begin
                  push_outcome(csq_pkg::STATUS_SUCCESS, 1'b0, '0, 1'b0, 1'b1);
               end
            end
            csq_pkg::MODE_TRYWAIT: begin
               if (count > 0) begin
                  count--;
                  push_outcome(csq_pkg::STATUS_SUCCESS, 1'b0, '0, 1'b0, 1'b1);
               end else begin
                  push_outcome(csq_pkg::STATUS_LOCKED, 1'b0, '0, 1'b0, 1'b1);
               end
            end
            default: begin
               closed = 1'b1;
               if (blocked_ids.size() == 0) begin
                  push_outcome(csq_pkg::STATUS_SUCCESS, 1'b0, '0, 1'b0, 1'b1);
               end else begin
                  while (blocked_ids.size() > 0) begin
                     id = blocked_ids.pop_front();
                     close_wakes++;
                     push_outcome(csq_pkg::STATUS_SUCCESS, 1'b1, id,
                                  csq_pkg::WAKE_CLOSED, blocked_ids.size() == 0);
                  end
               end
            end
         endcase
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            mismatches++;
            $error("%s: expected %0h, got %0h", field, want, got);
         end
      endfunction

      function void match_outcome(csq_pkg::rsp_type got);
         csq_pkg::rsp_type want;
         outcomes_seen++;
         if (due_outcomes.size() == 0) begin
            mismatches++;
            $error("unexpected transaction on result channel: %0h", got);
            return;
         end
         want = due_outcomes.pop_front();
         compare_field("status", 8'(want.status), 8'(got.status));
         compare_field("released_valid", 8'(want.released_valid),
                       8'(got.released_valid));
         compare_field("released_id", want.released_id, got.released_id);
         compare_field("wake_code", 8'(want.wake_code), 8'(got.wake_code));
         compare_field("last", 8'(want.last), 8'(got.last));
      endfunction

      function int pending();
         return due_outcomes.size();
      endfunction
   endclass

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   csq_pkg::req_type          req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   csq_pkg::rsp_type          rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [csq_pkg::CFG_W-1:0] csr_data  = '0;

   semaphore_shadow shadow;
   int unsigned req_idle_pct = 26;
   int unsigned rsp_idle_pct = 26;
   int unsigned hold_left    = 0;
   int unsigned quiet_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   counting_semaphore_wait_queue_top #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // result-side back-pressure, with an occasional long hold
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) shadow.match_outcome(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send_op(input logic [1:0] mode, input logic [ID_BITS-1:0] tid);
      csq_pkg::req_type item;
      item.mode      = mode;
      item.thread_id = tid;
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      shadow.apply_operation(item);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_initial_count(input logic [csq_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      shadow.reinit(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned pick, upper_wait, upper_signal;
      logic [1:0]  mode;
      logic [csq_pkg::CFG_W-1:0] start_count;
      bit          wait_heavy;

      shadow = new();
      shadow.reinit('0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // count 0 out of reset: lock, fill the queue, overflow, wake, close
      send_op(csq_pkg::MODE_TRYWAIT, 8'h00);
      send_op(csq_pkg::MODE_WAIT, 8'hFF);
      for (int k = 1; k < QUEUE_DEPTH; k++) send_op(csq_pkg::MODE_WAIT, 8'(k * 8'h11));
      send_op(csq_pkg::MODE_WAIT, 8'h55);
      send_op(csq_pkg::MODE_SIGNAL, 8'hAA);
      send_op(csq_pkg::MODE_WAIT, 8'h00);
      send_op(csq_pkg::MODE_CLOSE, 8'h00);
      send_op(csq_pkg::MODE_WAIT, 8'hFF);

      // saturated count
      settle();
      write_initial_count(16'hFFFF);
      send_op(csq_pkg::MODE_SIGNAL, 8'h0F);
      send_op(csq_pkg::MODE_TRYWAIT, 8'hF0);
      send_op(csq_pkg::MODE_WAIT, 8'h81);

      // close with nobody waiting
      settle();
      write_initial_count(16'h0000);
      send_op(csq_pkg::MODE_CLOSE, 8'h3C);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         if (phase == NUM_PHASES - 1) start_count = 16'hFFFF;
         else if (phase % 3 == 0) start_count = csq_pkg::CFG_W'($urandom_range(0, 65535));
         else if (phase % 3 == 1) start_count = csq_pkg::CFG_W'($urandom_range(0, 3));
         else start_count = '0;
         wait_heavy   = (phase % 3 == 2);
         upper_wait   = wait_heavy ? 70 : 40;
         upper_signal = wait_heavy ? 85 : 70;
         req_idle_pct = (phase == 3) ? 0 : 26;
         rsp_idle_pct = (phase == 3) ? 0 : 26;
         write_initial_count(start_count);
         if (phase == 5) hold_left = 80;
         for (int k = 0; k < PHASE_OPS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < upper_wait) mode = csq_pkg::MODE_WAIT;
            else if (pick < upper_signal) mode = csq_pkg::MODE_SIGNAL;
            else if (pick < 97) mode = csq_pkg::MODE_TRYWAIT;
            else mode = csq_pkg::MODE_CLOSE;
            send_op(mode, ID_BITS'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 1) == 1) begin
            send_op(csq_pkg::MODE_CLOSE, ID_BITS'($urandom_range(0, 255)));
            send_op(2'($urandom_range(0, 3)), ID_BITS'($urandom_range(0, 255)));
            send_op(2'($urandom_range(0, 3)), ID_BITS'($urandom_range(0, 255)));
         end
      end

      settle();
      repeat (10) @(posedge clock);
      $display("Ran %0d operations giving %0d results: %0d blocked, %0d queue full,",
               shadow.ops_seen, shadow.outcomes_seen, shadow.blocked_seen,
               shadow.full_seen);
      $display("%0d woken by signal, %0d woken by close, %0d refused after close.",
               shadow.signal_wakes, shadow.close_wakes, shadow.closed_seen);
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
